// ----- hw/rtl/cdda_pkg.sv -----
// Shared types and codes for the clamped DDA line rasterizer.
package cdda_pkg;

  localparam int POS_W = 17;
  localparam int CLAMP_W = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam int COORD_W = 16;
  localparam int COLOR_W = 8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE = 3'd4;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 13'd4096;
  localparam logic [COLOR_W-1:0] RED_RESET = 8'd0;
  localparam logic [COLOR_W-1:0] GREEN_RESET = 8'd0;
  localparam logic [COLOR_W-1:0] BLUE_RESET = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ----- hw/rtl/clamped_dda_line_rasterizer_core.sv -----
// Top level of the clamped DDA line rasterizer: slope divider, walk state and pixel output.
// A start beat computes the slope with a restoring divider that produces one quotient bit
// per cycle; a start passes through capture, FRAC_BITS+1 divide steps and emit, while
// a start whose endpoints coincide skips the divider. A step beat passes through advance
// and emit, or emits a no-line beat when no line is active. One beat is in flight at a time;
// the result waits in an output register, and the next input beat is taken while it is stalled there.
module clamped_dda_line_rasterizer_core #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_DIM = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cdda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cdda_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic signed [cdda_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [cdda_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [cdda_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [cdda_pkg::COORD_W-1:0]  in_end_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(MAX_DIM)-1:0]           out_pixel_x,
  output logic [$clog2(MAX_DIM)-1:0]           out_pixel_y,
  output logic [cdda_pkg::COLOR_W-1:0]         out_red,
  output logic [cdda_pkg::COLOR_W-1:0]         out_green,
  output logic [cdda_pkg::COLOR_W-1:0]         out_blue,
  output logic                                 out_last_pixel,
  output logic                                 out_no_line
);

  localparam int PIX_W = $clog2(MAX_DIM);
  localparam int ACC_W = FRAC_BITS + 18;
  localparam int Q_W = FRAC_BITS + 1;
  localparam int SLOPE_W = FRAC_BITS + 2;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int POS_W = cdda_pkg::POS_W;
  localparam int CW = cdda_pkg::CLAMP_W;

  cdda_pkg::state_t state_r, state_nxt;

  logic [cdda_pkg::CFG_DATA_W-1:0] width_r, width_nxt;
  logic [cdda_pkg::CFG_DATA_W-1:0] height_r, height_nxt;
  logic [cdda_pkg::COLOR_W-1:0] red_r, red_nxt;
  logic [cdda_pkg::COLOR_W-1:0] green_r, green_nxt;
  logic [cdda_pkg::COLOR_W-1:0] blue_r, blue_nxt;

  logic line_active_r, line_active_nxt;
  logic major_is_x_r, major_is_x_nxt;
  logic no_line_r, no_line_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic signed [POS_W-1:0] end_r, end_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [SLOPE_W-1:0] slope_r, slope_nxt;

  logic [POS_W-1:0] div_r, div_nxt;
  logic [POS_W:0] rem_r, rem_nxt;
  logic [Q_W-1:0] q_r, q_nxt;
  logic neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] px_r, px_nxt;
  logic [PIX_W-1:0] py_r, py_nxt;
  logic [cdda_pkg::COLOR_W-1:0] ored_r, ored_nxt;
  logic [cdda_pkg::COLOR_W-1:0] ogreen_r, ogreen_nxt;
  logic [cdda_pkg::COLOR_W-1:0] oblue_r, oblue_nxt;
  logic olast_r, olast_nxt;
  logic onl_r, onl_nxt;

  logic in_take;
  logic signed [POS_W-1:0] dx, dy;
  logic [POS_W-1:0] ax, ay;
  logic maj_x;
  logic signed [cdda_pkg::COORD_W-1:0] a0, a1, b0, b1, bs;
  logic signed [POS_W-1:0] dmaj, dmin;
  logic [POS_W:0] trial;
  logic ge;
  logic [PIX_W-1:0] lim_x, lim_y, lim_maj, lim_min;
  logic [PIX_W-1:0] maj_pix, min_pix;
  logic last;
  logic out_free;

  function automatic logic [PIX_W-1:0] clamp_pix(logic [CW-1:0] c, logic [PIX_W-1:0] lim);
    logic [PIX_W-1:0] r;
    if (c[CW-1]) begin
      r = '0;
    end else if (c[CW-2:0] > (CW-1)'(lim)) begin
      r = lim;
    end else begin
      r = c[PIX_W-1:0];
    end
    return r;
  endfunction

  assign in_stall = (state_r != cdda_pkg::ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (width_r == '0) begin
      lim_x = '0;
    end else if (32'(width_r) > 32'(MAX_DIM)) begin
      lim_x = PIX_W'(MAX_DIM - 1);
    end else begin
      lim_x = PIX_W'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      lim_y = '0;
    end else if (32'(height_r) > 32'(MAX_DIM)) begin
      lim_y = PIX_W'(MAX_DIM - 1);
    end else begin
      lim_y = PIX_W'(height_r - 1'b1);
    end
  end

  always_comb begin
    dx = {in_end_x[15], in_end_x} - {in_start_x[15], in_start_x};
    dy = {in_end_y[15], in_end_y} - {in_start_y[15], in_start_y};
    ax = dx[POS_W-1] ? -dx : dx;
    ay = dy[POS_W-1] ? -dy : dy;
    maj_x = (ax >= ay);
    if (maj_x) begin
      dmaj = dx;
      dmin = dy;
      a0 = in_start_x;
      a1 = in_end_x;
      b0 = in_start_y;
      b1 = in_end_y;
    end else begin
      dmaj = dy;
      dmin = dx;
      a0 = in_start_y;
      a1 = in_end_y;
      b0 = in_start_x;
      b1 = in_end_x;
    end
    bs = (a0 <= a1) ? b0 : b1;
  end

  always_comb begin
    trial = (cnt_r == '0) ? rem_r : {rem_r[POS_W-1:0], 1'b0};
    ge = (trial >= {1'b0, div_r});
  end

  always_comb begin
    lim_maj = major_is_x_r ? lim_x : lim_y;
    lim_min = major_is_x_r ? lim_y : lim_x;
    maj_pix = clamp_pix({pos_r[POS_W-1], pos_r}, lim_maj);
    min_pix = clamp_pix(acc_r[ACC_W-1:FRAC_BITS], lim_min);
    last = (pos_r >= end_r);
  end

  always_comb begin
    state_nxt = state_r;
    width_nxt = width_r;
    height_nxt = height_r;
    red_nxt = red_r;
    green_nxt = green_r;
    blue_nxt = blue_r;
    line_active_nxt = line_active_r;
    major_is_x_nxt = major_is_x_r;
    no_line_nxt = no_line_r;
    pos_nxt = pos_r;
    end_nxt = end_r;
    acc_nxt = acc_r;
    slope_nxt = slope_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    px_nxt = px_r;
    py_nxt = py_r;
    ored_nxt = ored_r;
    ogreen_nxt = ogreen_r;
    oblue_nxt = oblue_r;
    olast_nxt = olast_r;
    onl_nxt = onl_r;

    if (cfg_we) begin
      unique case (cfg_index)
        cdda_pkg::REG_WIDTH:  width_nxt = cfg_data;
        cdda_pkg::REG_HEIGHT: height_nxt = cfg_data;
        cdda_pkg::REG_RED:    red_nxt = cfg_data[cdda_pkg::COLOR_W-1:0];
        cdda_pkg::REG_GREEN:  green_nxt = cfg_data[cdda_pkg::COLOR_W-1:0];
        cdda_pkg::REG_BLUE:   blue_nxt = cfg_data[cdda_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      cdda_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_cmd == cdda_pkg::CMD_START) begin
            no_line_nxt = 1'b0;
            major_is_x_nxt = maj_x;
            if (a0 <= a1) begin
              pos_nxt = {a0[15], a0};
              end_nxt = {a1[15], a1};
            end else begin
              pos_nxt = {a1[15], a1};
              end_nxt = {a0[15], a0};
            end
            acc_nxt = {{(ACC_W-cdda_pkg::COORD_W-FRAC_BITS){bs[15]}}, bs, {FRAC_BITS{1'b0}}};
            div_nxt = maj_x ? ax : ay;
            rem_nxt = {1'b0, maj_x ? ay : ax};
            neg_nxt = dmaj[POS_W-1] ^ dmin[POS_W-1];
            q_nxt = '0;
            cnt_nxt = '0;
            slope_nxt = '0;
            state_nxt = (dmaj == '0) ? cdda_pkg::ST_EMIT : cdda_pkg::ST_DIV;
          end else if (!line_active_r) begin
            no_line_nxt = 1'b1;
            state_nxt = cdda_pkg::ST_EMIT;
          end else begin
            no_line_nxt = 1'b0;
            pos_nxt = pos_r + 1'b1;
            acc_nxt = acc_r + ACC_W'(slope_r);
            state_nxt = cdda_pkg::ST_EMIT;
          end
        end
      end
      cdda_pkg::ST_DIV: begin
        rem_nxt = ge ? (trial - {1'b0, div_r}) : trial;
        q_nxt = {q_r[Q_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          slope_nxt = neg_r ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt});
          state_nxt = cdda_pkg::ST_EMIT;
        end
      end
      cdda_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (no_line_r) begin
            px_nxt = '0;
            py_nxt = '0;
            ored_nxt = '0;
            ogreen_nxt = '0;
            oblue_nxt = '0;
            olast_nxt = 1'b0;
            onl_nxt = 1'b1;
          end else begin
            px_nxt = major_is_x_r ? maj_pix : min_pix;
            py_nxt = major_is_x_r ? min_pix : maj_pix;
            ored_nxt = red_r;
            ogreen_nxt = green_r;
            oblue_nxt = blue_r;
            olast_nxt = last;
            onl_nxt = 1'b0;
            line_active_nxt = !last;
          end
          state_nxt = cdda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cdda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdda_pkg::ST_IDLE;
      width_r <= cdda_pkg::DIM_RESET;
      height_r <= cdda_pkg::DIM_RESET;
      red_r <= cdda_pkg::RED_RESET;
      green_r <= cdda_pkg::GREEN_RESET;
      blue_r <= cdda_pkg::BLUE_RESET;
      line_active_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      width_r <= width_nxt;
      height_r <= height_nxt;
      red_r <= red_nxt;
      green_r <= green_nxt;
      blue_r <= blue_nxt;
      line_active_r <= line_active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_is_x_r <= major_is_x_nxt;
    no_line_r <= no_line_nxt;
    pos_r <= pos_nxt;
    end_r <= end_nxt;
    acc_r <= acc_nxt;
    slope_r <= slope_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    px_r <= px_nxt;
    py_r <= py_nxt;
    ored_r <= ored_nxt;
    ogreen_r <= ogreen_nxt;
    oblue_r <= oblue_nxt;
    olast_r <= olast_nxt;
    onl_r <= onl_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_red = ored_r;
  assign out_green = ogreen_r;
  assign out_blue = oblue_r;
  assign out_last_pixel = olast_r;
  assign out_no_line = onl_r;

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdda_pkg::ST_DIV) |-> (rem_r <= {1'b0, div_r}))
    else $error("divider remainder exceeds divisor");

  a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_line) |-> (out_pixel_x == '0 && out_pixel_y == '0 &&
      !out_last_pixel && out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("no-line beat carries pixel data");

  a_emit_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdda_pkg::ST_EMIT && out_free && !no_line_r && last) |=> !line_active_r)
    else $error("line still active after its last pixel");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdda_pkg::ST_DIV || state_r == cdda_pkg::ST_EMIT) |-> in_stall)
    else $error("input taken while a beat is in flight");

endmodule
